// ===== hdl/sra_pkg.sv =====
// ============================================================================
// sra_pkg
// Shared widths, register indexes, word types and controller states of the
// sparse row averaging block.
// ============================================================================
package sra_pkg;

    localparam int COLUMN_W    = 10;
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 48;
    localparam int COUNT_W     = 11;
    localparam int AVG_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Present marks are packed into words of MARK_W columns.
    localparam int MARK_W     = 32;
    localparam int MARK_BIT_W = 5;

    // Divider operands: magnitude of 2*sum + n, and 2*n.
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = COUNT_W + 1;
    localparam int PROD_W = VALUE_W + COUNT_W + 1;

    localparam int ROW_LENGTH_DEFAULT = 1024;
    localparam int MAX_FILES_DEFAULT  = 1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_COUNT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_VALUE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_ENABLE = 2'd2;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [COUNT_W-1:0] FILE_COUNT_RESET = 11'd1;

    localparam logic [AVG_W-1:0] AVG_MAX = 32'h7FFF_FFFF;
    localparam logic [AVG_W-1:0] AVG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                       action;
        logic [COLUMN_W-1:0]        column;
        logic signed [VALUE_W-1:0]  value;
    } item_word_t;

    typedef struct packed {
        logic                       found;
        logic [COLUMN_W-1:0]        out_column;
        logic signed [AVG_W-1:0]    average;
        logic                       kept;
        logic                       last;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RMW,
        ST_DRAIN_FIND,
        ST_DRAIN_SUM,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/sra_word_if.sv =====
// ============================================================================
// sra_word_if
// Valid/ready channel that moves one word of a given type per handshake.
// ============================================================================
interface sra_word_if #(
    parameter type word_t = logic
);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/sra_ram.sv =====
// ============================================================================
// sra_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module sra_ram #(
    parameter int   WIDTH  = 32,
    parameter int   DEPTH  = 32,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sra_div.sv =====
// ============================================================================
// sra_div
// Restoring unsigned divider that retires one quotient bit per cycle.
// ============================================================================
module sra_div #(
    parameter int NUM_W = sra_pkg::NUM_W,
    parameter int DEN_W = sra_pkg::DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // The next numerator bit is shifted into the partial remainder each step.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numerator;
            rem_reg <= '0;
            den_reg <= denominator;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/sparse_row_average.sv =====
// ============================================================================
// sparse_row_average
// An add word is read, then written back, and the next word is accepted
// right after it. A drain of a non-empty row passes the find, sum, divide
// and emit states, the divider retiring one quotient bit per cycle (49
// steps); a drain of an empty row goes straight to emit. Emit waits while
// the output register holds an untaken word. Reset clears the present marks
// at once through per-row valid bits; the sum memory needs no clearing pass.
// ============================================================================
module sparse_row_average #(
    parameter int ROW_LENGTH = sra_pkg::ROW_LENGTH_DEFAULT,
    parameter int MAX_FILES  = sra_pkg::MAX_FILES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sra_pkg::CFG_DATA_W-1:0]  cfg_data,
    sra_word_if.sink                       item,
    sra_word_if.source                     result
);

    // Only columns that the column field can name are ever stored.
    localparam int COLUMN_SPAN = 1 << sra_pkg::COLUMN_W;
    localparam int COLS        = (ROW_LENGTH < COLUMN_SPAN) ? ROW_LENGTH : COLUMN_SPAN;
    localparam int COL_ADDR_W  = $clog2(COLS);
    localparam int MARK_ROWS   = (COLS + sra_pkg::MARK_W - 1) / sra_pkg::MARK_W;
    localparam int ROW_ADDR_W  = (MARK_ROWS > 1) ? $clog2(MARK_ROWS) : 1;
    localparam bit CLAMP_FILES = (MAX_FILES < (1 << sra_pkg::COUNT_W));

    localparam int SUM_W  = sra_pkg::SUM_W;
    localparam int NUM_W  = sra_pkg::NUM_W;
    localparam int PROD_W = sra_pkg::PROD_W;
    localparam int AVG_W  = sra_pkg::AVG_W;
    localparam int MARK_W = sra_pkg::MARK_W;

    // Lowest mark row that holds any present column.
    function automatic logic [ROW_ADDR_W-1:0] lowest_row(input logic [MARK_ROWS-1:0] bits);
        logic [ROW_ADDR_W-1:0] idx;
        idx = '0;
        for (int i = MARK_ROWS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                idx = ROW_ADDR_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest present column inside one mark word.
    function automatic logic [sra_pkg::MARK_BIT_W-1:0] lowest_bit(input logic [MARK_W-1:0] bits);
        logic [sra_pkg::MARK_BIT_W-1:0] idx;
        idx = '0;
        for (int i = MARK_W - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                idx = sra_pkg::MARK_BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers. Write only while the block is idle; it is unchecked.
    // ------------------------------------------------------------------------
    logic [sra_pkg::COUNT_W-1:0]       file_count_reg;
    logic signed [sra_pkg::VALUE_W-1:0] threshold_value_reg;
    logic                              threshold_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_count_reg       <= sra_pkg::FILE_COUNT_RESET;
            threshold_value_reg  <= '0;
            threshold_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sra_pkg::CFG_FILE_COUNT:
                    file_count_reg <= cfg_data[sra_pkg::COUNT_W-1:0];
                sra_pkg::CFG_THRESHOLD_VALUE:
                    threshold_value_reg <= $signed(cfg_data[sra_pkg::VALUE_W-1:0]);
                sra_pkg::CFG_THRESHOLD_ENABLE:
                    threshold_enable_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // The divisor: a zero count acts as one, and counts above the file limit
    // are held at the limit.
    logic [sra_pkg::COUNT_W-1:0] n_eff;

    always_comb
    begin
        n_eff = file_count_reg;
        if (file_count_reg == '0)
        begin
            n_eff = sra_pkg::COUNT_W'(1);
        end
        else if (CLAMP_FILES && (32'(file_count_reg) > MAX_FILES))
        begin
            n_eff = sra_pkg::COUNT_W'(MAX_FILES);
        end
    end

    // ------------------------------------------------------------------------
    // Storage. Column sums live in one RAM word per column. Present marks are
    // packed into words of MARK_W columns in a second RAM, and each mark word
    // has a row bit in flip-flops. A clear row bit means the whole word reads
    // as empty, so reset clears every mark at once and stale RAM contents are
    // never seen.
    // ------------------------------------------------------------------------
    logic                    sum_we;
    logic [COL_ADDR_W-1:0]   sum_waddr;
    logic [SUM_W-1:0]        sum_wdata;
    logic [COL_ADDR_W-1:0]   sum_raddr;
    logic [SUM_W-1:0]        sum_rdata;

    logic                    mark_we;
    logic [ROW_ADDR_W-1:0]   mark_waddr;
    logic [MARK_W-1:0]       mark_wdata;
    logic [ROW_ADDR_W-1:0]   mark_raddr;
    logic [MARK_W-1:0]       mark_rdata;

    sra_ram #(
        .WIDTH (SUM_W),
        .DEPTH (COLS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    sra_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MARK_ROWS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // ------------------------------------------------------------------------
    // Controller and datapath registers.
    // ------------------------------------------------------------------------
    sra_pkg::state_t          state_reg;
    sra_pkg::state_t          state_next;
    logic [MARK_ROWS-1:0]     summary_reg;
    sra_pkg::item_word_t      item_reg;
    logic [ROW_ADDR_W-1:0]    drain_row_reg;
    logic [sra_pkg::COLUMN_W-1:0] drain_col_reg;
    logic                     more_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    sra_pkg::result_word_t    pend_reg;
    sra_pkg::result_word_t    pend_next;
    logic                     pend_load;
    sra_pkg::result_word_t    result_reg;
    logic                     result_valid_reg;
    logic                     result_load;
    logic                     item_ready;
    logic                     item_accept;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quotient;

    // Incoming column split into its mark row and its bit inside that row.
    logic [ROW_ADDR_W-1:0]    in_row;
    logic [COL_ADDR_W-1:0]    in_col_addr;
    logic                     in_range;

    assign in_row      = ROW_ADDR_W'(item.data.column[sra_pkg::COLUMN_W-1:sra_pkg::MARK_BIT_W]);
    assign in_col_addr = COL_ADDR_W'(item.data.column);
    assign in_range    = (32'(item.data.column) < COLS);
    assign item_accept = item.valid && item_ready;
    assign item.ready  = item_ready;

    // Read-modify-write of an add: the held column selects its row and bit.
    logic [ROW_ADDR_W-1:0]            add_row;
    logic [sra_pkg::MARK_BIT_W-1:0]   add_bit;
    logic [MARK_W-1:0]                add_mark_old;
    logic                             add_present;
    logic [SUM_W:0]                   add_acc;
    logic [SUM_W-1:0]                 add_sat;
    logic [SUM_W-1:0]                 add_first;

    assign add_row      = ROW_ADDR_W'(item_reg.column[sra_pkg::COLUMN_W-1:sra_pkg::MARK_BIT_W]);
    assign add_bit      = item_reg.column[sra_pkg::MARK_BIT_W-1:0];
    assign add_mark_old = summary_reg[add_row] ? mark_rdata : '0;
    assign add_present  = add_mark_old[add_bit];
    assign add_first    = {{(SUM_W - sra_pkg::VALUE_W){item_reg.value[sra_pkg::VALUE_W-1]}},
                           item_reg.value};
    assign add_acc      = {sum_rdata[SUM_W-1], sum_rdata} + {add_first[SUM_W-1], add_first};

    // The two top bits of the widened sum disagree only on overflow; the
    // sum then sticks at the end of the range in the direction it overflowed.
    always_comb
    begin
        if (add_acc[SUM_W] != add_acc[SUM_W-1])
        begin
            add_sat = add_acc[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            add_sat = add_acc[SUM_W-1:0];
        end
    end

    // Drain search: the row was chosen from the row bits on acceptance, the
    // word read back gives the column, and that mark is cleared in place.
    logic [sra_pkg::MARK_BIT_W-1:0] find_bit;
    logic [MARK_W-1:0]              find_word_clr;
    logic [MARK_ROWS-1:0]           other_rows;
    logic                           find_more;
    logic [sra_pkg::COLUMN_W-1:0]   find_col;

    assign find_bit      = lowest_bit(mark_rdata);
    assign find_word_clr = mark_rdata & ~(MARK_W'(1) << find_bit);
    assign other_rows    = summary_reg & ~(MARK_ROWS'(1) << drain_row_reg);
    assign find_more     = (find_word_clr != '0) || (other_rows != '0);
    assign find_col      = sra_pkg::COLUMN_W'({drain_row_reg, find_bit});

    // Rounded average floor((2*sum + n) / (2*n)). A negative numerator is
    // divided as its complement, whose quotient complemented is the floor.
    logic [NUM_W:0]              num_full;
    logic [NUM_W-1:0]            num_mag;
    logic [sra_pkg::DEN_W-1:0]   den;
    logic signed [PROD_W-1:0]    prod_next;

    assign num_full  = {sum_rdata[SUM_W-1], sum_rdata, 1'b0} + (NUM_W + 1)'(n_eff);
    assign num_mag   = num_full[NUM_W] ? ~num_full[NUM_W-1:0] : num_full[NUM_W-1:0];
    assign den       = {n_eff, 1'b0};
    assign prod_next = $signed(threshold_value_reg) * $signed({1'b0, n_eff});

    sra_div #(
        .NUM_W (NUM_W),
        .DEN_W (sra_pkg::DEN_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (num_mag),
        .denominator (den),
        .done        (div_done),
        .quotient    (div_quotient)
    );

    // The quotient magnitude saturates symmetrically: for a negative result
    // the complement of anything past 31 bits falls below the 32-bit range.
    logic                     avg_ovf;
    logic [AVG_W-1:0]         avg_value;
    logic signed [SUM_W-1:0]  prod_ext;
    logic                     keep;

    assign avg_ovf  = |div_quotient[NUM_W-1:AVG_W-1];
    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign keep     = !threshold_enable_reg || (sum_reg >= prod_ext);

    always_comb
    begin
        if (avg_ovf)
        begin
            avg_value = neg_reg ? sra_pkg::AVG_MIN : sra_pkg::AVG_MAX;
        end
        else
        begin
            avg_value = neg_reg ? ~div_quotient[AVG_W-1:0] : div_quotient[AVG_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // State machine. Words are taken only in the idle state; a finished
    // result waits in the output register while the next word is taken.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        sum_we      = 1'b0;
        mark_we     = 1'b0;
        div_start   = 1'b0;
        pend_load   = 1'b0;
        result_load = 1'b0;
        pend_next   = '0;

        mark_raddr = (item.data.action == sra_pkg::ACT_DRAIN) ? lowest_row(summary_reg) : in_row;
        sum_raddr  = (state_reg == sra_pkg::ST_DRAIN_FIND) ? COL_ADDR_W'(find_col) : in_col_addr;

        sum_waddr  = COL_ADDR_W'(item_reg.column);
        sum_wdata  = add_present ? add_sat : add_first;
        mark_waddr = (state_reg == sra_pkg::ST_ADD_RMW) ? add_row : drain_row_reg;
        mark_wdata = (state_reg == sra_pkg::ST_ADD_RMW) ? (add_mark_old | (MARK_W'(1) << add_bit))
                                                        : find_word_clr;

        unique case (state_reg)
            sra_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item.valid)
                begin
                    if (item.data.action == sra_pkg::ACT_ADD)
                    begin
                        // Columns past the row are dropped without a memory access.
                        if (in_range)
                        begin
                            state_next = sra_pkg::ST_ADD_RMW;
                        end
                    end
                    else if (summary_reg == '0)
                    begin
                        pend_next.last = 1'b1;
                        pend_load      = 1'b1;
                        state_next     = sra_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = sra_pkg::ST_DRAIN_FIND;
                    end
                end
            end
            sra_pkg::ST_ADD_RMW:
            begin
                sum_we     = 1'b1;
                mark_we    = 1'b1;
                state_next = sra_pkg::ST_IDLE;
            end
            sra_pkg::ST_DRAIN_FIND:
            begin
                mark_we    = 1'b1;
                state_next = sra_pkg::ST_DRAIN_SUM;
            end
            sra_pkg::ST_DRAIN_SUM:
            begin
                div_start  = 1'b1;
                state_next = sra_pkg::ST_DIV;
            end
            sra_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    pend_next.found      = 1'b1;
                    pend_next.out_column = drain_col_reg;
                    pend_next.average    = avg_value;
                    pend_next.kept       = keep;
                    pend_next.last       = !more_reg;
                    pend_load            = 1'b1;
                    state_next           = sra_pkg::ST_EMIT;
                end
            end
            sra_pkg::ST_EMIT:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    result_load = 1'b1;
                    state_next  = sra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sra_pkg::ST_IDLE;
            end
        endcase
    end

    // Row bits: set by every in-range add, cleared when a drain empties its word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg <= '0;
        end
        else if (state_reg == sra_pkg::ST_ADD_RMW)
        begin
            summary_reg[add_row] <= 1'b1;
        end
        else if ((state_reg == sra_pkg::ST_DRAIN_FIND) && (find_word_clr == '0))
        begin
            summary_reg[drain_row_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg      <= item.data;
            drain_row_reg <= lowest_row(summary_reg);
        end
        if (state_reg == sra_pkg::ST_DRAIN_FIND)
        begin
            drain_col_reg <= find_col;
            more_reg      <= find_more;
        end
        if (state_reg == sra_pkg::ST_DRAIN_SUM)
        begin
            sum_reg  <= $signed(sum_rdata);
            neg_reg  <= num_full[NUM_W];
            prod_reg <= prod_next;
        end
        if (pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (result_load)
        begin
            result_reg <= pend_reg;
        end
    end

    // Output register: holds a word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

`ifndef NO_ASSERTIONS
    a_add_sets_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sra_pkg::ST_ADD_RMW) |=> summary_reg[$past(add_row)])
        else $error("add did not mark its row present");

    a_last_empties_row: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sra_pkg::ST_DRAIN_FIND) && !find_more) |=> (summary_reg == '0))
        else $error("entries remain after a drain flagged as last");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sra_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == sra_pkg::ST_EMIT))
        else $error("result word appeared without passing the emit state");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking regression for sparse_row_average. Add and drain words are
// driven into the item channel. A predictor keeps its own per-column sums,
// present marks and register copies, and computes the entry that each drain
// must return. Result words are compared field by field against the oldest
// queued entry. Directed tests cover the extremes, rounding, the threshold
// and sums that grow far past the 32-bit range. Random phases under changing
// register settings then follow, with idle bursts on both channels; one
// directed test holds back results for a long stretch.
// ============================================================================
module testbench;

    localparam int COLUMN_W    = sra_pkg::COLUMN_W;
    localparam int VALUE_W     = sra_pkg::VALUE_W;
    localparam int SUM_W       = sra_pkg::SUM_W;
    localparam int COUNT_W     = sra_pkg::COUNT_W;
    localparam int AVG_W       = sra_pkg::AVG_W;
    localparam int CFG_INDEX_W = sra_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = sra_pkg::CFG_DATA_W;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    // Settle time after the last queued entry is back, before touching
    // registers or ending the run.
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int ROW_LENGTH    = sra_pkg::ROW_LENGTH_DEFAULT;
    localparam int MAX_FILES     = sra_pkg::MAX_FILES_DEFAULT;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int FINAL_ITEMS   = 200;
    // Adds of an extreme value per column in the wide-sum test; enough to
    // carry a sum far beyond what a 32-bit average can hold.
    localparam int WIDE_ADDS     = 50;

    // Index 3 maps to no register, so the block must ignore writes to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [VALUE_W-1:0] VALUE_TOP    = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_BOTTOM = 32'h8000_0000;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint AVG_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint AVG_LO = -AVG_HI - 1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sra_word_if #(.word_t(sra_pkg::item_word_t))   item_ch ();
    sra_word_if #(.word_t(sra_pkg::result_word_t)) result_ch ();

    sparse_row_average u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the row and of the three registers.
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0] col_sum [ROW_LENGTH];
    bit                      col_present [ROW_LENGTH];
    logic [COUNT_W-1:0]      file_count_reg = sra_pkg::FILE_COUNT_RESET;
    logic signed [31:0]      limit_value    = '0;
    logic                    limit_enable   = 1'b0;

    sra_pkg::result_word_t expected_entries[$];

    int fail_count    = 0;
    int items_sent    = 0;
    bit idle_on       = 1'b0;
    bit hold_request  = 1'b0;

    // Number of columns that are marked present right now.
    function automatic int present_total();
        int total;
        total = 0;
        foreach (col_present[i])
            total += col_present[i];
        return total;
    endfunction

    // Applies one accepted item word to the private row. A drain queues the
    // entry that the block must return for it.
    function automatic void predict_row_item(input sra_pkg::item_word_t w);
        sra_pkg::result_word_t r;
        longint                acc;
        longint                n;
        longint                num;
        longint                den;
        longint                q;
        int                    hit;
        bit                    got_hit;
        bit                    more;

        r       = '0;
        got_hit = 1'b0;
        more    = 1'b0;
        hit     = 0;
        if (w.action == sra_pkg::ACT_ADD)
        begin
            // A 10-bit column always lies inside the 1024-column row, so an
            // add to a column beyond the row cannot be produced here.
            if (!col_present[w.column])
            begin
                // The first add to an absent column overwrites whatever the
                // sum store held, so no unwritten sum is ever read.
                acc = longint'($signed(w.value));
                col_present[w.column] = 1'b1;
            end
            else
            begin
                acc = longint'(col_sum[w.column]) + longint'($signed(w.value));
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
            end
            col_sum[w.column] = acc[SUM_W-1:0];
            return;
        end

        for (int i = 0; i < ROW_LENGTH; i++)
        begin
            if (col_present[i])
            begin
                if (!got_hit)
                begin
                    got_hit = 1'b1;
                    hit     = i;
                end
                else
                begin
                    more = 1'b1;
                    break;
                end
            end
        end

        if (!got_hit)
        begin
            // Empty row: everything zero except the last flag.
            r.last = 1'b1;
        end
        else
        begin
            col_present[hit] = 1'b0;
            if (file_count_reg == 0)
                n = 1;
            else if (file_count_reg > MAX_FILES)
                n = MAX_FILES;
            else
                n = file_count_reg;
            acc = col_sum[hit];
            // Round half up: floor((2*sum + n) / 2n). The division truncates
            // toward zero, so inexact negative quotients step down by one.
            num = 2 * acc + n;
            den = 2 * n;
            q   = num / den;
            if (num % den != 0 && num < 0)
                q = q - 1;
            if (q > AVG_HI)
                q = AVG_HI;
            if (q < AVG_LO)
                q = AVG_LO;
            r.found      = 1'b1;
            r.out_column = hit[COLUMN_W-1:0];
            r.average    = q[AVG_W-1:0];
            // The threshold compares the exact average, so scale it by n.
            r.kept       = !limit_enable || (acc >= longint'(limit_value) * n);
            r.last       = !more;
        end
        expected_entries = {expected_entries, r};
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. Each accepted result word is matched against the
    // oldest queued entry, field by field.
    // ------------------------------------------------------------------------
    task automatic check_entry(input sra_pkg::result_word_t got);
        sra_pkg::result_word_t want;
        if (expected_entries.size() == 0)
        begin
            $error("result word with no entry pending: %p", got);
            fail_count++;
            return;
        end
        want = expected_entries.pop_front();
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            fail_count++;
        end
        if (got.out_column !== want.out_column)
        begin
            $error("out_column: expected %0d, actual %0d", want.out_column,
                   got.out_column);
            fail_count++;
        end
        if (got.average !== want.average)
        begin
            $error("average: expected %0d, actual %0d", $signed(want.average),
                   $signed(got.average));
            fail_count++;
        end
        if (got.kept !== want.kept)
        begin
            $error("kept: expected %0d, actual %0d", want.kept, got.kept);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_entry(result_ch.data);
    end

    // ------------------------------------------------------------------------
    // Result receiver. Ready drops in random bursts while idling is on. A
    // hold request keeps ready low until a stall count loaded from LONG_HOLD
    // runs out, so that the block backs up into its item input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        stall           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 15);
            result_ch.ready <= (stall == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sparse_row_average regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Item sender. Valid is only lowered for an idle gap or a pause, so that a
    // word that follows straight on from the last one keeps valid high with
    // no second assignment in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(input sra_pkg::item_word_t w);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_row_item(w);
        items_sent++;
    endtask

    function automatic sra_pkg::item_word_t add_word(input logic [COLUMN_W-1:0] column,
                                                     input logic [VALUE_W-1:0] value);
        sra_pkg::item_word_t w;
        w.action = sra_pkg::ACT_ADD;
        w.column = column;
        w.value  = value;
        return w;
    endfunction

    // Column and value of a drain are ignored by the block; random bits there
    // make sure the block really ignores them.
    function automatic sra_pkg::item_word_t drain_word();
        sra_pkg::item_word_t w;
        w.action = sra_pkg::ACT_DRAIN;
        w.column = COLUMN_W'($urandom());
        w.value  = $urandom();
        return w;
    endfunction

    // Mix of extremes, full-range values and small values near zero, the
    // last so that rounding and threshold decisions fall both ways.
    function automatic logic [VALUE_W-1:0] pick_value();
        int s;
        case ($urandom_range(0, 7))
            0:       return VALUE_TOP;
            1:       return VALUE_BOTTOM;
            2, 3, 4: return $urandom();
            default:
            begin
                s = int'($urandom_range(0, 400)) - 200;
                return s;
            end
        endcase
    endfunction

    // Stops offering words, waits until every queued entry has come back and
    // then lets the block finish any add that is still in flight.
    task automatic wait_until_idle();
        item_ch.valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; apply_settings lowers it after the last
    // write so that back-to-back writes never assign it twice in one step.
    task automatic put_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            sra_pkg::CFG_FILE_COUNT:       file_count_reg = data[COUNT_W-1:0];
            sra_pkg::CFG_THRESHOLD_VALUE:  limit_value    = data;
            sra_pkg::CFG_THRESHOLD_ENABLE: limit_enable   = data[0];
            default:                       ;
        endcase
    endtask

    // Writes all registers while the block is idle. Bits above the file count
    // and the enable carry random junk that the block must drop, and the unused
    // index gets a random write that must change nothing.
    task automatic apply_settings(input logic [COUNT_W-1:0] file_count,
                                  input logic [31:0] threshold,
                                  input logic enable);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom();
        wait_until_idle();
        put_register(sra_pkg::CFG_FILE_COUNT, {junk[CFG_DATA_W-1:COUNT_W], file_count});
        put_register(sra_pkg::CFG_THRESHOLD_VALUE, threshold);
        put_register(CFG_UNUSED, $urandom());
        put_register(sra_pkg::CFG_THRESHOLD_ENABLE, {junk[CFG_DATA_W-1:1], enable});
        cfg_we <= 1'b0;
    endtask

    // One row's worth of traffic. Most groups are well formed: a run of adds,
    // then enough drains to empty the row and sometimes one more that finds
    // it empty. Some stop draining early, which leaves entries behind for
    // the next group, and some are a single random word.
    task automatic send_row_group();
        logic [COLUMN_W-1:0] palette [4];
        sra_pkg::item_word_t w;
        int                  adds;
        int                  drains;
        int                  mode;
        bit                  narrow;

        mode = $urandom_range(0, 19);
        if (mode >= 17)
        begin
            w.action = 1'($urandom_range(0, 1));
            w.column = COLUMN_W'($urandom());
            w.value  = pick_value();
            send_word(w);
            return;
        end
        // A narrow group reuses a few columns, so sums accumulate.
        narrow = 1'($urandom_range(0, 1));
        foreach (palette[i])
            palette[i] = COLUMN_W'($urandom());
        adds = $urandom_range(1, 12);
        repeat (adds)
        begin
            if (narrow)
                send_word(add_word(palette[2'($urandom_range(0, 3))], pick_value()));
            else
                send_word(add_word(COLUMN_W'($urandom()), pick_value()));
        end
        if (mode >= 14)
            drains = $urandom_range(0, present_total());
        else
            drains = present_total() + $urandom_range(0, 1);
        repeat (drains) send_word(drain_word());
    endtask

    function automatic logic [31:0] pick_threshold();
        int s;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return VALUE_BOTTOM;
            2:       return VALUE_TOP;
            3:       return $urandom();
            default:
            begin
                s = int'($urandom_range(0, 200)) - 100;
                return s;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: one file, threshold off. Covers the empty row, both
    // column ends, both value extremes and a 32-bit average that saturates.
    task automatic test_directed_extremes();
        send_word(drain_word());
        send_word(add_word(10'd0, VALUE_TOP));
        send_word(add_word(10'd1023, VALUE_BOTTOM));
        send_word(add_word(10'd0, VALUE_TOP));
        send_word(add_word(10'd512, 32'hFFFF_FFFF));
        send_word(add_word(10'd5, 32'd0));
        repeat (5) send_word(drain_word());
    endtask

    // Two files: exact halves round up, and a negative sum just under zero
    // is flagged by a threshold of zero.
    task automatic test_rounding_and_threshold();
        apply_settings(11'd2, 32'd0, 1'b1);
        send_word(add_word(10'd3, 32'd1));
        send_word(add_word(10'd4, 32'hFFFF_FFFF));
        send_word(add_word(10'd6, 32'hFFFF_FFFD));
        send_word(add_word(10'd7, VALUE_BOTTOM));
        repeat (4) send_word(drain_word());
    endtask

    // A file count of zero acts as one, and one above the maximum acts as
    // the maximum.
    task automatic test_file_count_limits();
        apply_settings(11'd0, VALUE_BOTTOM, 1'b1);
        send_word(add_word(10'd9, VALUE_BOTTOM));
        send_word(drain_word());
        apply_settings(11'd2047, VALUE_TOP, 1'b1);
        send_word(add_word(10'd10, VALUE_TOP));
        send_word(drain_word());
    endtask

    // Drives one sum far above the 32-bit range and another far below it, so
    // both averages saturate, then pulls a third one back by an add of the
    // opposite sign.
    task automatic test_wide_sums();
        apply_settings(11'd1, VALUE_TOP, 1'b1);
        idle_on = 1'b0;
        repeat (WIDE_ADDS)
        begin
            send_word(add_word(10'd100, VALUE_TOP));
            send_word(add_word(10'd101, VALUE_BOTTOM));
        end
        send_word(add_word(10'd102, VALUE_TOP));
        send_word(add_word(10'd102, VALUE_TOP));
        repeat (WIDE_ADDS) send_word(add_word(10'd102, VALUE_TOP));
        send_word(add_word(10'd102, VALUE_BOTTOM));
        repeat (4) send_word(drain_word());
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the block fills and stalls its input. The sender then pauses until
    // every result is back before it goes on.
    task automatic test_result_backpressure();
        apply_settings(11'd3, 32'd0, 1'b0);
        idle_on      = 1'b0;
        hold_request = 1'b1;
        repeat (8) send_word(add_word(COLUMN_W'($urandom()), pick_value()));
        repeat (present_total() + 1) send_word(drain_word());
        repeat (4) send_row_group();
        wait_until_idle();
        idle_on = 1'b1;
        repeat (4) send_row_group();
    endtask

    // Random phases, each under new register settings. The file count runs
    // through its extremes in turn; some phases go without idling.
    task automatic test_random_phases();
        logic [COUNT_W-1:0] file_count;
        int                 stop_at;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 8)
                0:       file_count = 11'd1;
                1:       file_count = 11'd1024;
                2:       file_count = 11'd2047;
                3:       file_count = 11'd0;
                4:       file_count = 11'd2;
                5:       file_count = COUNT_W'($urandom_range(1025, 2046));
                default: file_count = COUNT_W'($urandom_range(1, 1024));
            endcase
            apply_settings(file_count, pick_threshold(), p[0]);
            idle_on = (p % 4 != 3);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
                send_row_group();
        end
    endtask

    // The last stretch runs with no idling on either side.
    task automatic test_random_quiet_finish();
        int stop_at;
        apply_settings(COUNT_W'($urandom_range(1, 1024)), pick_threshold(),
                       1'($urandom_range(0, 1)));
        idle_on = 1'b0;
        stop_at = items_sent + FINAL_ITEMS;
        while (items_sent < stop_at)
            send_row_group();
    endtask

    initial
    begin : main
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = sra_pkg::CFG_FILE_COUNT;
        cfg_data      = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_rounding_and_threshold();
        test_file_count_limits();
        test_wide_sums();
        test_result_backpressure();
        test_random_phases();
        test_random_quiet_finish();

        wait_until_idle();
        if (fail_count == 0)
            $display("sparse_row_average regression: pass");
        else
            $display("sparse_row_average regression: fail");
        $finish;
    end

endmodule
